>>> src/thpc_pkg.sv
package thpc_pkg;

    // Magnitude ceiling for intermediate products (2^61).
    localparam logic [61:0] MAG_CAP  = 62'h2000_0000_0000_0000;
    // Ceiling for phase durations (2^32).
    localparam logic [32:0] TIME_CAP = 33'h1_0000_0000;

    typedef logic [2:0] thpc_cfg_idx_t;
    localparam thpc_cfg_idx_t CFG_GAIN_P       = 3'd0;
    localparam thpc_cfg_idx_t CFG_MAX_VELOCITY = 3'd1;
    localparam thpc_cfg_idx_t CFG_MAX_ACCEL    = 3'd2;
    localparam thpc_cfg_idx_t CFG_TARGET       = 3'd3;
    localparam thpc_cfg_idx_t CFG_START        = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_VV,
        ST_AD,
        ST_DQ,
        ST_SQ,
        ST_DRAW,
        ST_DFULL,
        ST_X,
        ST_H,
        ST_M
    } thpc_state_t;

    typedef enum logic [1:0] {
        PH_ACCEL,
        PH_CRUISE,
        PH_DECEL,
        PH_DONE
    } thpc_phase_t;

    // Profile constants derived from the configuration.
    typedef struct packed {
        logic [32:0] ta;
        logic [32:0] tc;
        logic [61:0] vp;
        logic [61:0] hacc;
        logic [62:0] hcr;
        logic [33:0] t1;
        logic [34:0] t2;
    } thpc_params_t;

    function automatic logic [61:0] capsh(input logic [95:0] p, input int unsigned sh);
        logic [95:0] s;
        s = p >> sh;
        if (s > {34'b0, MAG_CAP}) begin
            return MAG_CAP;
        end
        return s[61:0];
    endfunction

    function automatic logic [31:0] sat32(input logic [63:0] v);
        if ($signed(v) > 64'sd2147483647) begin
            return 32'h7fff_ffff;
        end
        if ($signed(v) < -64'sd2147483648) begin
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

endpackage

>>> src/thpc_setup.sv
module thpc_setup
    import thpc_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         restart,
    input  logic [30:0]  acc_lim,
    input  logic [30:0]  vel_lim,
    input  logic [32:0]  travel,
    output logic         busy,
    output thpc_params_t params
);

    thpc_state_t state_reg, state_next;
    logic        start_reg;
    logic [5:0]  cnt_reg;

    logic [95:0] mcand_reg, acc_reg, mul_sum;
    logic [32:0] mplier_reg;
    logic [63:0] num_reg, quot;
    logic [31:0] rem_reg, rem_new;
    logic [30:0] den_reg;
    logic [32:0] rem_sh;
    logic        div_ge;
    logic [63:0] rad_reg;
    logic [33:0] srem_reg;
    logic [35:0] srem_sh, trial;
    logic [31:0] root_reg, root_new;
    logic        sq_ge;

    logic [61:0] mul_a;
    logic [32:0] mul_b;
    logic [63:0] div_n;
    logic [30:0] div_d;
    logic [5:0]  iter_cnt;
    logic        step_done;

    logic [63:0] vv_reg, q_reg, raw_reg;
    logic        tri_reg;
    logic [32:0] ta_reg, tc_reg;
    logic [61:0] vp_reg, x_reg, hacc_reg;
    logic [62:0] hcr_reg;
    logic [33:0] t1_reg;
    logic [34:0] t2_reg;

    logic [63:0] trap_diff;
    logic [32:0] tc_trap, ta_trap;
    logic        q_ovf;
    logic [61:0] x_val, h_val;

    assign mul_sum = acc_reg + (mplier_reg[0] ? mcand_reg : 96'd0);

    assign rem_sh  = {rem_reg, num_reg[63]};
    assign div_ge  = rem_sh >= {2'b0, den_reg};
    assign rem_new = div_ge ? 32'(rem_sh - {2'b0, den_reg}) : rem_sh[31:0];
    assign quot    = {num_reg[62:0], div_ge};

    assign srem_sh  = {srem_reg, rad_reg[63:62]};
    assign trial    = {2'b0, root_reg, 2'b01};
    assign sq_ge    = srem_sh >= trial;
    assign root_new = {root_reg[30:0], sq_ge};

    assign step_done = !start_reg && (cnt_reg == 6'd0);

    assign trap_diff = (quot > raw_reg) ? quot - raw_reg : 64'd0;
    assign tc_trap   = (trap_diff > {31'b0, TIME_CAP}) ? TIME_CAP : trap_diff[32:0];
    assign ta_trap   = (raw_reg > {31'b0, TIME_CAP}) ? TIME_CAP : raw_reg[32:0];
    assign q_ovf     = (quot >> (64 - FRAC_BITS)) != 64'd0;
    assign x_val     = capsh(mul_sum, FRAC_BITS);
    assign h_val     = capsh(mul_sum, FRAC_BITS + 1);

    // Operand selection for the unit that the coming state uses.
    always_comb begin
        mul_a    = 62'd0;
        mul_b    = 33'd0;
        div_n    = 64'd0;
        div_d    = 31'd1;
        iter_cnt = 6'd0;
        unique case (state_reg)
            ST_IDLE: begin
            end
            ST_VV: begin
                mul_a    = {31'b0, vel_lim};
                mul_b    = {2'b0, vel_lim};
                iter_cnt = 6'd32;
            end
            ST_AD: begin
                mul_a    = {31'b0, acc_lim};
                mul_b    = travel;
                iter_cnt = 6'd32;
            end
            ST_DQ: begin
                div_n    = 64'(travel) << FRAC_BITS;
                div_d    = acc_lim;
                iter_cnt = 6'd63;
            end
            ST_SQ: begin
                iter_cnt = 6'd31;
            end
            ST_DRAW: begin
                div_n    = 64'(vel_lim) << FRAC_BITS;
                div_d    = acc_lim;
                iter_cnt = 6'd63;
            end
            ST_DFULL: begin
                div_n    = 64'(travel) << FRAC_BITS;
                div_d    = vel_lim;
                iter_cnt = 6'd63;
            end
            ST_X: begin
                mul_a    = {31'b0, acc_lim};
                mul_b    = ta_reg;
                iter_cnt = 6'd32;
            end
            ST_H: begin
                mul_a    = x_reg;
                mul_b    = ta_reg;
                iter_cnt = 6'd32;
            end
            ST_M: begin
                mul_a    = vp_reg;
                mul_b    = tc_reg;
                iter_cnt = 6'd32;
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        busy       = state_reg != ST_IDLE;
        if (restart) begin
            state_next = ST_VV;
        end else begin
            unique case (state_reg)
                ST_IDLE: state_next = ST_IDLE;
                ST_VV: begin
                    if (step_done) state_next = ST_AD;
                end
                ST_AD: begin
                    if (step_done) state_next = (vv_reg > mul_sum[63:0]) ? ST_DQ : ST_DRAW;
                end
                ST_DQ: begin
                    if (step_done) state_next = q_ovf ? ST_X : ST_SQ;
                end
                ST_SQ: begin
                    if (step_done) state_next = ST_X;
                end
                ST_DRAW: begin
                    if (step_done) state_next = ST_DFULL;
                end
                ST_DFULL: begin
                    if (step_done) state_next = ST_X;
                end
                ST_X: begin
                    if (step_done) state_next = ST_H;
                end
                ST_H: begin
                    if (step_done) state_next = ST_M;
                end
                ST_M: begin
                    if (step_done) state_next = ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_VV;
            start_reg <= 1'b1;
        end else begin
            state_reg <= state_next;
            start_reg <= restart || (state_next != state_reg);
        end
    end

    // The first cycle of each state loads its unit; the following cycles iterate.
    always_ff @(posedge aclk) begin
        if (start_reg) begin
            mcand_reg  <= {34'b0, mul_a};
            mplier_reg <= mul_b;
            acc_reg    <= 96'd0;
            num_reg    <= div_n;
            den_reg    <= div_d;
            rem_reg    <= 32'd0;
            rad_reg    <= q_reg << FRAC_BITS;
            srem_reg   <= 34'd0;
            root_reg   <= 32'd0;
            cnt_reg    <= iter_cnt;
        end else begin
            mcand_reg  <= mcand_reg << 1;
            mplier_reg <= mplier_reg >> 1;
            acc_reg    <= mul_sum;
            num_reg    <= quot;
            rem_reg    <= rem_new;
            rad_reg    <= rad_reg << 2;
            srem_reg   <= sq_ge ? 34'(srem_sh - trial) : srem_sh[33:0];
            root_reg   <= root_new;
            if (cnt_reg != 6'd0) begin
                cnt_reg <= cnt_reg - 6'd1;
            end
            if (cnt_reg == 6'd0) begin
                unique case (state_reg)
                    ST_IDLE: begin
                    end
                    ST_VV: vv_reg <= mul_sum[63:0];
                    ST_AD: tri_reg <= vv_reg > mul_sum[63:0];
                    ST_DQ: begin
                        q_reg  <= quot;
                        tc_reg <= 33'd0;
                        if (q_ovf) ta_reg <= TIME_CAP;
                    end
                    ST_SQ: ta_reg <= {1'b0, root_new};
                    ST_DRAW: raw_reg <= quot;
                    ST_DFULL: begin
                        tc_reg <= tc_trap;
                        ta_reg <= ta_trap;
                        vp_reg <= {31'b0, vel_lim};
                    end
                    ST_X: begin
                        x_reg <= x_val;
                        if (tri_reg) vp_reg <= x_val;
                    end
                    ST_H: hacc_reg <= h_val;
                    ST_M: begin
                        hcr_reg <= {1'b0, hacc_reg} + {1'b0, x_val};
                        t1_reg  <= {1'b0, ta_reg} + {1'b0, tc_reg};
                        t2_reg  <= {2'b0, ta_reg} + {2'b0, tc_reg} + {2'b0, ta_reg};
                    end
                endcase
            end
        end
    end

    assign params.ta   = ta_reg;
    assign params.tc   = tc_reg;
    assign params.vp   = vp_reg;
    assign params.hacc = hacc_reg;
    assign params.hcr  = hcr_reg;
    assign params.t1   = t1_reg;
    assign params.t2   = t2_reg;

    a_idle_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE && !restart) |=> (state_reg == ST_IDLE))
        else $error("setup left idle without a configuration write");

    a_last_step_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_M && step_done && !restart) |=> !busy)
        else $error("setup did not finish after its last product");

    a_ta_capped: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_H && start_reg) |-> (ta_reg <= TIME_CAP))
        else $error("acceleration time above its ceiling");

endmodule

>>> src/trapezoid_height_profile_p_control_top.sv
// Trapezoidal height profile with proportional control. Each input beat carries the elapsed
// time and the measured height; each output beat gives the profile height, half the profile
// velocity and the acceleration command. One beat can enter every cycle unless the output
// or setup stalls it, through seven register stages with multipliers of at most 32 by 32
// bits. After reset and after every configuration write, a setup sequencer works out the
// phase times, peak velocity and plateau heights with a shift-add multiplier, a restoring
// divider and a square root unit, one bit per cycle, while s_tready is low. The user must
// write configuration only while no beat is in flight; the block does not enforce it.
module trapezoid_height_profile_p_control_top
    import thpc_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // elapsed_time [31:0], measured_z [63:32]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // height_setpoint [31:0], velocity_setpoint [63:32],
                                   // accel_command [95:64]
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_wdata
);

    localparam int VPW = 63 - FRAC_BITS;
    localparam int HIW = VPW - 32;
    localparam int MW  = FRAC_BITS + 34;

    logic [30:0] gain_reg, vmax_reg, amax_reg;
    logic [31:0] tgt_reg, hstart_reg;
    logic [30:0] acc_lim, vel_lim;
    logic [32:0] diff, travel;
    logic        busy;
    thpc_params_t params;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg   <= 31'(1) << FRAC_BITS;
            vmax_reg   <= 31'(1) << FRAC_BITS;
            amax_reg   <= 31'(1) << FRAC_BITS;
            tgt_reg    <= 32'd0;
            hstart_reg <= 32'd0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_GAIN_P:       gain_reg   <= cfg_wdata[30:0];
                CFG_MAX_VELOCITY: vmax_reg   <= cfg_wdata[30:0];
                CFG_MAX_ACCEL:    amax_reg   <= cfg_wdata[30:0];
                CFG_TARGET:       tgt_reg    <= cfg_wdata;
                CFG_START:        hstart_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // A zero limit behaves as one LSB.
    assign acc_lim = (amax_reg == 31'd0) ? 31'd1 : amax_reg;
    assign vel_lim = (vmax_reg == 31'd0) ? 31'd1 : vmax_reg;
    assign diff    = {tgt_reg[31], tgt_reg} - {hstart_reg[31], hstart_reg};
    assign travel  = diff[32] ? 33'(-diff) : diff;

    thpc_setup #(
        .FRAC_BITS(FRAC_BITS)
    ) u_setup (
        .aclk    (aclk),
        .aresetn (aresetn),
        .restart (cfg_wr_en),
        .acc_lim (acc_lim),
        .vel_lim (vel_lim),
        .travel  (travel),
        .busy    (busy),
        .params  (params)
    );

    // Stage readiness: a stage moves when it is empty or the one after it moves.
    logic p1_vld_reg, p2_vld_reg, p3_vld_reg, p4_vld_reg, p5_vld_reg, p6_vld_reg, p7_vld_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdy7;

    assign rdy7     = !p7_vld_reg || m_tready;
    assign rdy6     = !p6_vld_reg || rdy7;
    assign rdy5     = !p5_vld_reg || rdy6;
    assign rdy4     = !p4_vld_reg || rdy5;
    assign rdy3     = !p3_vld_reg || rdy4;
    assign rdy2     = !p2_vld_reg || rdy3;
    assign rdy1     = !p1_vld_reg || rdy2;
    assign s_tready = rdy1 && !busy;
    assign m_tvalid = p7_vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_vld_reg <= 1'b0;
            p2_vld_reg <= 1'b0;
            p3_vld_reg <= 1'b0;
            p4_vld_reg <= 1'b0;
            p5_vld_reg <= 1'b0;
            p6_vld_reg <= 1'b0;
            p7_vld_reg <= 1'b0;
        end else begin
            if (rdy1) p1_vld_reg <= s_tvalid && s_tready;
            if (rdy2) p2_vld_reg <= p1_vld_reg;
            if (rdy3) p3_vld_reg <= p2_vld_reg;
            if (rdy4) p4_vld_reg <= p3_vld_reg;
            if (rdy5) p5_vld_reg <= p4_vld_reg;
            if (rdy6) p6_vld_reg <= p5_vld_reg;
            if (rdy7) p7_vld_reg <= p6_vld_reg;
        end
    end

    // Stage 1: phase decision and time within the phase.
    logic [31:0] in_e, in_z;
    logic [34:0] e_ext;
    thpc_phase_t ph_c;
    logic [31:0] t_c;

    assign in_e  = s_tdata[31:0];
    assign in_z  = s_tdata[63:32];
    assign e_ext = {3'b0, in_e};

    always_comb begin
        priority if (e_ext < {2'b0, params.ta}) begin
            ph_c = PH_ACCEL;
            t_c  = in_e;
        end else if (e_ext < {1'b0, params.t1}) begin
            ph_c = PH_CRUISE;
            t_c  = 32'(e_ext - {2'b0, params.ta});
        end else if (e_ext < params.t2) begin
            ph_c = PH_DECEL;
            t_c  = 32'(e_ext - {1'b0, params.t1});
        end else begin
            ph_c = PH_DONE;
            t_c  = 32'd0;
        end
    end

    thpc_phase_t p1_ph_reg;
    logic [31:0] p1_t_reg, p1_z_reg;

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            p1_ph_reg <= ph_c;
            p1_t_reg  <= t_c;
            p1_z_reg  <= in_z;
        end
    end

    // Stage 2: A*t and the two halves of vp*t.
    logic [62:0]     at_full;
    logic [63:0]     lin_lo_c;
    logic [HIW+31:0] lin_hi_c;

    assign at_full  = {32'b0, acc_lim} * {31'b0, p1_t_reg};
    assign lin_lo_c = {32'b0, params.vp[31:0]} * {32'b0, p1_t_reg};
    assign lin_hi_c = {32'b0, params.vp[VPW-1:32]} * {{HIW{1'b0}}, p1_t_reg};

    thpc_phase_t     p2_ph_reg;
    logic [31:0]     p2_t_reg, p2_z_reg;
    logic [VPW-1:0]  p2_at_reg;
    logic [63:0]     p2_lin_lo_reg;
    logic [HIW+31:0] p2_lin_hi_reg;

    always_ff @(posedge aclk) begin
        if (rdy2) begin
            p2_ph_reg     <= p1_ph_reg;
            p2_t_reg      <= p1_t_reg;
            p2_z_reg      <= p1_z_reg;
            p2_at_reg     <= at_full[62:FRAC_BITS];
            p2_lin_lo_reg <= lin_lo_c;
            p2_lin_hi_reg <= lin_hi_c;
        end
    end

    // Stage 3: the halves of (A*t)*t, and vp*t finished.
    logic [63:0]     sq_lo_c;
    logic [HIW+31:0] sq_hi_c;
    logic [61:0]     lin_c;

    assign sq_lo_c = {32'b0, p2_at_reg[31:0]} * {32'b0, p2_t_reg};
    assign sq_hi_c = {32'b0, p2_at_reg[VPW-1:32]} * {{HIW{1'b0}}, p2_t_reg};
    assign lin_c   = capsh(96'(p2_lin_lo_reg) + (96'(p2_lin_hi_reg) << 32), FRAC_BITS);

    thpc_phase_t     p3_ph_reg;
    logic [31:0]     p3_z_reg;
    logic [VPW-1:0]  p3_at_reg;
    logic [63:0]     p3_sq_lo_reg;
    logic [HIW+31:0] p3_sq_hi_reg;
    logic [61:0]     p3_lin_reg;

    always_ff @(posedge aclk) begin
        if (rdy3) begin
            p3_ph_reg    <= p2_ph_reg;
            p3_z_reg     <= p2_z_reg;
            p3_at_reg    <= p2_at_reg;
            p3_sq_lo_reg <= sq_lo_c;
            p3_sq_hi_reg <= sq_hi_c;
            p3_lin_reg   <= lin_c;
        end
    end

    // Stage 4: profile height, velocity and feed-forward for the phase.
    logic [61:0] sq_c;
    logic [63:0] h_c, v_c, at_ext;
    logic [31:0] ff_c;

    assign sq_c   = capsh(96'(p3_sq_lo_reg) + (96'(p3_sq_hi_reg) << 32), FRAC_BITS + 1);
    assign at_ext = 64'(p3_at_reg);

    always_comb begin
        unique case (p3_ph_reg)
            PH_ACCEL: begin
                h_c  = {2'b0, sq_c};
                v_c  = at_ext;
                ff_c = {1'b0, acc_lim};
            end
            PH_CRUISE: begin
                h_c  = {2'b0, params.hacc} + {2'b0, p3_lin_reg};
                v_c  = {2'b0, params.vp};
                ff_c = 32'd0;
            end
            PH_DECEL: begin
                h_c  = {1'b0, params.hcr} + {2'b0, p3_lin_reg} - {2'b0, sq_c};
                v_c  = {2'b0, params.vp} - at_ext;
                ff_c = 32'(-{1'b0, acc_lim});
            end
            PH_DONE: begin
                h_c  = {{32{tgt_reg[31]}}, tgt_reg};
                v_c  = 64'd0;
                ff_c = 32'd0;
            end
        endcase
    end

    logic [63:0] p4_h_reg, p4_v_reg;
    logic [31:0] p4_ff_reg, p4_z_reg;

    always_ff @(posedge aclk) begin
        if (rdy4) begin
            p4_h_reg  <= h_c;
            p4_v_reg  <= v_c;
            p4_ff_reg <= ff_c;
            p4_z_reg  <= p3_z_reg;
        end
    end

    // Stage 5: height error and its clamped magnitude. Beyond the clamp the command
    // saturates for every non-zero gain, so the clamp changes no result.
    logic [64:0]   err_c, mag_full;
    logic [64:0]   mag_clamp;
    logic [MW-1:0] mag_c;
    logic [63:0]   v_adj;

    assign err_c     = {p4_h_reg[63], p4_h_reg} + {{33{p4_z_reg[31]}}, p4_z_reg};
    assign mag_full  = err_c[64] ? 65'(-err_c) : err_c;
    assign mag_clamp = 65'(1) << (FRAC_BITS + 33);
    assign mag_c     = (mag_full > mag_clamp) ? mag_clamp[MW-1:0] : mag_full[MW-1:0];
    assign v_adj     = p4_v_reg + {63'b0, p4_v_reg[63]};

    logic [MW-1:0] p5_mag_reg;
    logic          p5_neg_reg;
    logic [31:0]   p5_ff_reg, p5_hs_reg, p5_vs_reg;

    always_ff @(posedge aclk) begin
        if (rdy5) begin
            p5_mag_reg <= mag_c;
            p5_neg_reg <= err_c[64];
            p5_ff_reg  <= p4_ff_reg;
            p5_hs_reg  <= sat32(p4_h_reg);
            p5_vs_reg  <= sat32({v_adj[63], v_adj[63:1]});
        end
    end

    // Stage 6: gain times error magnitude, in two halves.
    logic [62:0]          gp_lo_c;
    logic [MW-32+30:0]    gp_hi_c;

    assign gp_lo_c = {31'b0, p5_mag_reg[31:0]} * {32'b0, gain_reg};
    assign gp_hi_c = {31'b0, p5_mag_reg[MW-1:32]} * {{(MW-32){1'b0}}, gain_reg};

    logic [62:0]       p6_gp_lo_reg;
    logic [MW-32+30:0] p6_gp_hi_reg;
    logic              p6_neg_reg;
    logic [31:0]       p6_ff_reg, p6_hs_reg, p6_vs_reg;

    always_ff @(posedge aclk) begin
        if (rdy6) begin
            p6_gp_lo_reg <= gp_lo_c;
            p6_gp_hi_reg <= gp_hi_c;
            p6_neg_reg   <= p5_neg_reg;
            p6_ff_reg    <= p5_ff_reg;
            p6_hs_reg    <= p5_hs_reg;
            p6_vs_reg    <= p5_vs_reg;
        end
    end

    // Stage 7: command and output register.
    logic [61:0] prod_c;
    logic [63:0] sprod_c, cmd_c;

    assign prod_c  = capsh(96'(p6_gp_lo_reg) + (96'(p6_gp_hi_reg) << 32), FRAC_BITS);
    assign sprod_c = p6_neg_reg ? 64'(-{2'b0, prod_c}) : {2'b0, prod_c};
    assign cmd_c   = 64'(-({{32{p6_ff_reg[31]}}, p6_ff_reg} + sprod_c));

    logic [95:0] out_reg;

    always_ff @(posedge aclk) begin
        if (rdy7) begin
            out_reg <= {sat32(cmd_c), p6_vs_reg, p6_hs_reg};
        end
    end

    assign m_tdata = out_reg;

    a_cfg_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr_en |=> !s_tready)
        else $error("input accepted while the profile is being recomputed");

    a_out_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !p6_vld_reg) |=> !m_tvalid)
        else $error("output beat repeated");

    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> p1_vld_reg)
        else $error("accepted beat lost at pipeline entry");

endmodule
